/* sv/amsd_pkg.sv */
// amsd_pkg: constants, register indexes and controller/datapath structs
// for the adaptive median spike detector; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package amsd_pkg;
  localparam int WINDOW   = 200;
  localparam int CHANNELS = 4;

  localparam int POS_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 48;
  localparam int THR_W    = 20;
  localparam int GAIN_W   = 12;
  localparam int SCALE_W  = 16;
  localparam int LEN_W    = 6;
  localparam int CONF_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam int THR_SHIFT = 23;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_LEN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POST_LEN    = 3'd7;

  typedef struct packed {
    logic             load;       // request accepted, latch samples and read delay line
    logic             det_commit; // apply detection step
    logic             med_rd;     // median pass memory read
    logic             med_bit;    // resolve one median bit
    logic             thr_a;      // first threshold product
    logic             thr_b;      // second product, saturate, store
    logic [POS_W-1:0] addr;
    logic [3:0]       bit_idx;
    logic [CH_W-1:0]  ch;
  } amsd_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
    logic wrap;
  } amsd_sts_t;
endpackage
`default_nettype wire

/* sv/amsd_in_if.sv */
// amsd_in_if: input request channel, one time step of samples
// depends on amsd_pkg
`timescale 1ns / 1ps
`default_nettype none
interface amsd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [amsd_pkg::SAMPLE_W-1:0] sample_ch0;
  logic signed [amsd_pkg::SAMPLE_W-1:0] sample_ch1;
  logic signed [amsd_pkg::SAMPLE_W-1:0] sample_ch2;
  logic signed [amsd_pkg::SAMPLE_W-1:0] sample_ch3;
  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface
`default_nettype wire

/* sv/amsd_out_if.sv */
// amsd_out_if: result channel, at most one confirmed spike per request
// depends on amsd_pkg
`timescale 1ns / 1ps
`default_nettype none
interface amsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [amsd_pkg::TIME_W-1:0]   peak_time;
  logic [1:0]                    trigger_channel;
  logic [amsd_pkg::SAMPLE_W-1:0] peak_magnitude;
  logic [amsd_pkg::THR_W-1:0]    threshold_used;
  modport source (output valid, peak_time, trigger_channel, peak_magnitude,
                  threshold_used, input ready);
  modport sink (input valid, peak_time, trigger_channel, peak_magnitude,
                threshold_used, output ready);
endinterface
`default_nettype wire

/* sv/amsd_ctrl.sv */
// amsd_ctrl: sequencer for detection step, radix median passes and
// threshold products; depends on amsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module amsd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire amsd_pkg::amsd_sts_t sts_i,
  output amsd_pkg::amsd_cmd_t      cmd_o
);
  import amsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DET, S_MED_RD, S_MED_WAIT, S_MED_BIT, S_THR_A, S_THR_B
  } state_e;

  state_e           state_q;
  logic [POS_W-1:0] a_q;
  logic [3:0]       b_q;
  logic [CH_W-1:0]  ch_q;
  logic             det_ok;

  assign det_ok     = !(sts_i.emit && sts_i.out_busy);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.addr       = a_q;
    cmd_o.bit_idx    = b_q;
    cmd_o.ch         = ch_q;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.det_commit = (state_q == S_DET) && det_ok;
    cmd_o.med_rd     = (state_q == S_MED_RD);
    cmd_o.med_bit    = (state_q == S_MED_BIT);
    cmd_o.thr_a      = (state_q == S_THR_A);
    cmd_o.thr_b      = (state_q == S_THR_B);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      ch_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DET;
        end
        S_DET: begin
          if (det_ok) begin
            if (sts_i.wrap) begin
              a_q     <= '0;
              b_q     <= 4'd15;
              state_q <= S_MED_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_MED_RD: begin
          if (a_q == POS_W'(WINDOW - 1)) state_q <= S_MED_WAIT;
          else a_q <= a_q + 1'b1;
        end
        S_MED_WAIT: state_q <= S_MED_BIT;
        S_MED_BIT: begin
          a_q <= '0;
          if (b_q == 4'd0) begin
            ch_q    <= '0;
            state_q <= S_THR_A;
          end else begin
            b_q     <= b_q - 1'b1;
            state_q <= S_MED_RD;
          end
        end
        S_THR_A: state_q <= S_THR_B;
        S_THR_B: begin
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_THR_A;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/amsd_dp.sv */
// amsd_dp: delay line memory, radix median select, threshold products,
// peak detection state and result register; depends on amsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module amsd_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire amsd_pkg::amsd_cmd_t                  cmd_i,
  output amsd_pkg::amsd_sts_t                       sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [amsd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [3:0][amsd_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic [amsd_pkg::TIME_W-1:0]               peak_time_o,
  output logic [1:0]                                trigger_channel_o,
  output logic [amsd_pkg::SAMPLE_W-1:0]             peak_magnitude_o,
  output logic [amsd_pkg::THR_W-1:0]                threshold_used_o
);
  import amsd_pkg::*;

  typedef enum logic [1:0] {PH_SCAN, PH_CLIMB, PH_CONFIRM, PH_SKIP} phase_e;

  // configuration
  logic [GAIN_W-1:0]  gain_q [CHANNELS];
  logic [3:0]         mask_q;
  logic [SCALE_W-1:0] scale_q;
  logic [LEN_W-1:0]   pre_q, post_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) gain_q[c] <= GAIN_W'(1024);
      mask_q  <= 4'hF;
      scale_q <= SCALE_W'(32768);
      pre_q   <= LEN_W'(12);
      post_q  <= LEN_W'(21);
    end else if (cfg_we_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (cfg_idx_i == REG_GAIN0 + CFG_IDX_W'(c)) gain_q[c] <= cfg_data_i[GAIN_W-1:0];
      end
      if (cfg_idx_i == REG_ACTIVE_MASK) mask_q  <= cfg_data_i[3:0];
      if (cfg_idx_i == REG_NOISE_SCALE) scale_q <= cfg_data_i[SCALE_W-1:0];
      if (cfg_idx_i == REG_PRE_LEN)     pre_q   <= cfg_data_i[LEN_W-1:0];
      if (cfg_idx_i == REG_POST_LEN)    post_q  <= cfg_data_i[LEN_W-1:0];
    end
  end

  // delay line memory, one row holds all channel magnitudes of a time step
  logic [CHANNELS-1:0][SAMPLE_W-1:0] mem [WINDOW];
  logic [CHANNELS-1:0][SAMPLE_W-1:0] rd_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] mag_q;
  logic [POS_W-1:0]                  pos_q;
  logic [POS_W-1:0]                  rd_addr;

  assign rd_addr = cmd_i.med_rd ? cmd_i.addr : pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.med_rd) rd_q <= mem[rd_addr];
    if (cmd_i.det_commit) mem[pos_q] <= mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mag_q[c] <= sample_i[c][SAMPLE_W-1] ? SAMPLE_W'(-sample_i[c]) : sample_i[c];
      end
    end
  end

  // radix select of the median, one bit per pass over the window
  logic             acc_q;
  logic [SAMPLE_W-1:0] pfx_q [CHANNELS];
  logic [CNT_W-1:0]    k_q   [CHANNELS];
  logic [CNT_W-1:0]    cnt_q [CHANNELS];
  logic [SAMPLE_W-1:0] hi_mask;

  assign hi_mask = SAMPLE_W'(17'h1FFFF << ({1'b0, cmd_i.bit_idx} + 5'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= 1'b0;
    else acc_q <= cmd_i.med_rd;
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd_i.det_commit && sts_o.wrap) begin
        pfx_q[c] <= '0;
        k_q[c]   <= CNT_W'(WINDOW / 2);
        cnt_q[c] <= '0;
      end else if (cmd_i.med_bit) begin
        if (k_q[c] >= cnt_q[c]) begin
          pfx_q[c][cmd_i.bit_idx] <= 1'b1;
          k_q[c] <= k_q[c] - cnt_q[c];
        end
        cnt_q[c] <= '0;
      end else if (acc_q) begin
        if ((((rd_q[c] ^ pfx_q[c]) & hi_mask) == '0) && !rd_q[c][cmd_i.bit_idx])
          cnt_q[c] <= cnt_q[c] + 1'b1;
      end
    end
  end

  // threshold = median * noise_scale * gain >> 23, saturated
  logic [2*SAMPLE_W-1:0]         p1_q;
  logic [2*SAMPLE_W+GAIN_W-1:0]  p2;
  logic [2*SAMPLE_W+GAIN_W-THR_SHIFT-1:0] p2_sh;
  logic [THR_W-1:0]              thr_q [CHANNELS];

  assign p2    = (2*SAMPLE_W+GAIN_W)'(p1_q) * (2*SAMPLE_W+GAIN_W)'(gain_q[cmd_i.ch]);
  assign p2_sh = p2[2*SAMPLE_W+GAIN_W-1:THR_SHIFT];

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_a) p1_q <= (2*SAMPLE_W)'(pfx_q[cmd_i.ch]) * (2*SAMPLE_W)'(scale_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) thr_q[c] <= '0;
    end else if (cmd_i.thr_b) begin
      thr_q[cmd_i.ch] <= (p2_sh > (2*SAMPLE_W+GAIN_W-THR_SHIFT)'(THR_MAX)) ?
                         THR_MAX : p2_sh[THR_W-1:0];
    end
  end

  // detection state
  phase_e            phase_q, phase_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic [TIME_W-1:0] ctime_q, ctime_d;
  logic [CONF_W-1:0] conf_q, conf_d;
  logic [CH_W-1:0]   tch_q, tch_d;
  logic [THR_W-1:0]  tthr_q, tthr_d;
  logic [TIME_W-1:0] cnt48_q;
  logic              filled_q;

  logic [SAMPLE_W-1:0] dm [CHANNELS];
  logic [SAMPLE_W-1:0] m;
  logic [TIME_W-1:0]   d_time, gap;
  logic [CONF_W-1:0]   sum, target;
  logic                emit, hit;

  always_comb begin
    // entries of the first window are never written yet, read them as zero
    for (int c = 0; c < CHANNELS; c++) dm[c] = filled_q ? rd_q[c] : '0;
    m      = dm[tch_q];
    d_time = cnt48_q - TIME_W'(WINDOW);
    sum    = CONF_W'(pre_q) + CONF_W'(post_q);
    target = (sum > CONF_W'(1)) ? sum - 1'b1 : '0;
    phase_d = phase_q;
    peak_d  = peak_q;
    ctime_d = ctime_q;
    conf_d  = conf_q;
    tch_d   = tch_q;
    tthr_d  = tthr_q;
    emit    = 1'b0;
    hit     = 1'b0;
    case (phase_q)
      PH_SCAN: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (!hit && mask_q[c] && (THR_W'(dm[c]) > thr_q[c])) begin
            hit     = 1'b1;
            tch_d   = CH_W'(c);
            tthr_d  = thr_q[c];
            peak_d  = dm[c];
            ctime_d = d_time;
            phase_d = PH_CLIMB;
          end
        end
      end
      PH_CLIMB: begin
        if (m > peak_q) begin
          peak_d  = m;
          ctime_d = d_time;
        end else if (target == '0) begin
          emit = 1'b1;
        end else begin
          if (m < peak_q) begin
            conf_d = CONF_W'(1);
          end else begin
            peak_d  = m;
            ctime_d = d_time;
            conf_d  = '0;
          end
          phase_d = PH_CONFIRM;
          emit    = (conf_d >= target);
        end
      end
      PH_CONFIRM: begin
        if (m < peak_q) begin
          conf_d = conf_q + 1'b1;
        end else begin
          peak_d  = m;
          ctime_d = d_time;
          conf_d  = '0;
        end
        emit = (conf_d >= target);
      end
      default: begin
        if (conf_q != '0) conf_d = conf_q - 1'b1;
        if (conf_d == '0) phase_d = PH_SCAN;
      end
    endcase
    gap = d_time - ctime_d;
    if (emit) begin
      // resume after peak + post_peak_len
      if (TIME_W'(post_q) > gap) begin
        conf_d  = CONF_W'(post_q - gap[LEN_W-1:0]);
        phase_d = PH_SKIP;
      end else begin
        conf_d  = '0;
        phase_d = PH_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SCAN;
      peak_q   <= '0;
      ctime_q  <= '0;
      conf_q   <= '0;
      tch_q    <= '0;
      tthr_q   <= '0;
      cnt48_q  <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else if (cmd_i.det_commit) begin
      phase_q <= phase_d;
      peak_q  <= peak_d;
      ctime_q <= ctime_d;
      conf_q  <= conf_d;
      tch_q   <= tch_d;
      tthr_q  <= tthr_d;
      cnt48_q <= cnt48_q + 1'b1;
      if (pos_q == POS_W'(WINDOW - 1)) begin
        pos_q    <= '0;
        filled_q <= 1'b1;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // result register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.det_commit && emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.det_commit && emit) begin
      peak_time_o       <= ctime_d;
      trigger_channel_o <= 2'(tch_d);
      peak_magnitude_o  <= peak_d;
      threshold_used_o  <= tthr_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.emit     = emit;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.wrap     = (pos_q == POS_W'(WINDOW - 1));
endmodule
`default_nettype wire

/* sv/adaptive_median_spike_detector.sv */
// adaptive median spike detector, top level; depends on amsd_pkg,
// amsd_in_if, amsd_out_if, amsd_ctrl, amsd_dp
// one request at a time: delay line read, then detection step, which waits
//   if its result would overwrite an unaccepted one; each window's last
//   request is followed by bit-serial median passes and threshold products
// reset: asynchronous active low, registers to defaults, thresholds zero
`timescale 1ns / 1ps
`default_nettype none
module adaptive_median_spike_detector (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  amsd_in_if.sink                                 in_i,
  amsd_out_if.source                              out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [amsd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import amsd_pkg::*;

  amsd_cmd_t cmd;
  amsd_sts_t sts;
  logic [3:0][SAMPLE_W-1:0] samples;

  assign samples = {in_i.sample_ch3, in_i.sample_ch2, in_i.sample_ch1, in_i.sample_ch0};

  amsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amsd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .sample_i          (samples),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .peak_time_o       (out_o.peak_time),
    .trigger_channel_o (out_o.trigger_channel),
    .peak_magnitude_o  (out_o.peak_magnitude),
    .threshold_used_o  (out_o.threshold_used)
  );

  a_no_accept_in_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.med_rd |-> !in_i.ready) else $error("request accepted during median pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.det_commit |-> !(sts.emit && sts.out_busy)) else $error("result overwritten");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_i.ready) else $error("second request while busy");
endmodule
`default_nettype wire
